@@ rtl/core/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 16;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int SIZE_W       = 21;
    localparam int ADDR_W       = 33;
    localparam int BASE_W       = 32;
    localparam int ENTRY_W      = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] HDR    = SIZE_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] ALIGNV = SIZE_W'(ALIGN_BYTES);

    localparam logic [0:0] REQ_ALLOC = 1'b0;
    localparam logic [0:0] REQ_FREE  = 1'b1;

    localparam logic [0:0] REG_BASE  = 1'b0;
    localparam logic [0:0] REG_BYTES = 1'b1;

    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
    } entry_t;

endpackage

@@ rtl/core/first_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with split and coalescing over a block table.
// ----------------------------------------------------------------------------
// channel  direction  handshake                 content
// s_axis   in         s_axis_tvalid/tready      request: type, size, address
// m_axis   out        m_axis_tvalid/tready      response: ok, grant address
// cfg      in         cfg_valid/cfg_ready       register index and data
//
// A request walks the table one entry at a time; every entry moved by a split
// or a merge shift costs a further read and write, all through the one table RAM.
// A null free goes straight to the response without a table walk.
// Reset or a register write leaves one free block; no sweep is needed since
// entries beyond the block count are never read before being written.
// The block takes no request until the response has been taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // request_bytes[20:0], release_address[53:21]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // ok[0], grant_address[33:1]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_RD     = 13'b0000000000010,
        S_EVAL   = 13'b0000000000100,
        S_SHR    = 13'b0000000001000,
        S_SHW    = 13'b0000000010000,
        S_SPLIT  = 13'b0000000100000,
        S_SPLIT2 = 13'b0000001000000,
        S_MSTART = 13'b0000010000000,
        S_MRD    = 13'b0000100000000,
        S_MEVAL  = 13'b0001000000000,
        S_SHL    = 13'b0010000000000,
        S_SHLW   = 13'b0100000000000,
        S_RESP   = 13'b1000000000000
    } state_t;

    state_t            state_reg;
    logic [BASE_W-1:0] base_reg;
    logic [SIZE_W-1:0] bytes_reg;
    logic [CNT_W-1:0]  count_reg;
    entry_t            e0_reg;
    logic              type_reg;
    logic [SIZE_W:0]   need_reg;
    logic [ADDR_W-1:0] target_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  k_reg;
    entry_t            cur_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] grant_reg;
    logic [IDX_W-1:0]  rd_idx_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata, rdata_raw, rdata;

    logic              tw_en;
    logic [IDX_W-1:0]  tw_addr;
    entry_t            tw_data;

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    // entry 0 is kept in flops so reset/config need no RAM write
    assign rdata = (rd_idx_reg == '0) ? e0_reg : rdata_raw;
    assign we    = tw_en && (tw_addr != '0);
    assign waddr = tw_addr;
    assign wdata = tw_data;

    logic [SIZE_W-1:0] base_bytes;
    logic [SIZE_W-1:0] init_size;
    assign base_bytes = (cfg_index == REG_BYTES) ? cfg_data[SIZE_W-1:0] : bytes_reg;
    assign init_size  = (base_bytes >= HDR) ? base_bytes - HDR : '0;

    logic [SIZE_W:0] req_need;
    assign req_need = ({1'b0, s_axis_tdata[20:0]} + (SIZE_W+1)'(ALIGN_BYTES - 1))
                      & ~(SIZE_W+1)'(ALIGN_BYTES - 1);

    logic [SIZE_W+1:0] split_min;
    assign split_min = {1'b0, need_reg} + (SIZE_W+2)'(HEADER_BYTES + ALIGN_BYTES);

    logic [SIZE_W-1:0] new_size;
    assign new_size = cur_reg.size - need_reg[SIZE_W-1:0] - HDR;

    // shared adder for the address walk and the merged size
    logic [ADDR_W-1:0] sum_a, shared_sum;
    assign sum_a      = (state_reg == S_MEVAL) ? ADDR_W'(cur_reg.size) : addr_reg;
    assign shared_sum = sum_a + ADDR_W'(HEADER_BYTES) + ADDR_W'(rdata.size);

    logic [ADDR_W-1:0] hdr_addr;
    assign hdr_addr = addr_reg + ADDR_W'(HEADER_BYTES);

    logic alloc_fit, do_split, free_hit, both_free;
    assign alloc_fit = rdata.is_free && ({1'b0, rdata.size} >= need_reg);
    assign do_split  = ({2'b00, rdata.size} >= split_min) && (count_reg < CNT_W'(MAX_BLOCKS));
    assign free_hit  = (hdr_addr == target_reg);
    assign both_free = cur_reg.is_free && rdata.is_free;

    logic [CNT_W-1:0] ip1, km1, kp1;
    assign ip1 = i_reg + CNT_W'(1);
    assign km1 = k_reg - CNT_W'(1);
    assign kp1 = k_reg + CNT_W'(1);

    logic [IDX_W-1:0] i_idx, k_idx;
    assign i_idx = i_reg[IDX_W-1:0];
    assign k_idx = k_reg[IDX_W-1:0];

    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_RESP);
    assign m_axis_tdata  = {6'b0, grant_reg, ok_reg};

    always_comb
    begin
        tw_en   = 1'b0;
        tw_addr = i_idx;
        tw_data = cur_reg;
        raddr   = i_idx;
        unique case (state_reg)
            S_IDLE, S_MSTART, S_RESP:
            begin
            end
            S_RD:
            begin
                raddr = i_idx;
            end
            S_EVAL:
            begin
                if (type_reg == REQ_ALLOC)
                begin
                    tw_en = alloc_fit && !do_split;
                end
                else
                begin
                    tw_en = free_hit;
                end
                tw_data = '{is_free: (type_reg == REQ_FREE), size: rdata.size};
            end
            S_SHR:
            begin
                raddr = km1[IDX_W-1:0];
            end
            S_SHW:
            begin
                tw_en   = 1'b1;
                tw_addr = k_idx;
                tw_data = rdata;
            end
            S_SPLIT:
            begin
                tw_en   = 1'b1;
                tw_addr = ip1[IDX_W-1:0];
                tw_data = '{is_free: 1'b1, size: new_size};
            end
            S_SPLIT2:
            begin
                tw_en   = 1'b1;
                tw_data = '{is_free: 1'b0, size: need_reg[SIZE_W-1:0]};
            end
            S_MRD:
            begin
                raddr = ip1[IDX_W-1:0];
            end
            S_MEVAL:
            begin
                tw_en   = both_free;
                tw_data = '{is_free: 1'b1, size: shared_sum[SIZE_W-1:0]};
            end
            S_SHL:
            begin
                raddr = kp1[IDX_W-1:0];
            end
            S_SHLW:
            begin
                tw_en   = 1'b1;
                tw_addr = k_idx;
                tw_data = rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= '0;
            bytes_reg  <= SIZE_W'(65536);
            count_reg  <= CNT_W'(1);
            e0_reg     <= '{is_free: 1'b1, size: SIZE_W'(65536 - HEADER_BYTES)};
            type_reg   <= 1'b0;
            need_reg   <= '0;
            target_reg <= '0;
            addr_reg   <= '0;
            i_reg      <= '0;
            k_reg      <= '0;
            cur_reg    <= '0;
            ok_reg     <= 1'b0;
            grant_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= raddr;
            if (tw_en && tw_addr == '0)
            begin
                e0_reg <= tw_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == REG_BASE)
                        begin
                            base_reg <= cfg_data;
                        end
                        else
                        begin
                            bytes_reg <= cfg_data[SIZE_W-1:0];
                        end
                        e0_reg    <= '{is_free: 1'b1, size: init_size};
                        count_reg <= CNT_W'(1);
                    end
                    else if (s_axis_tvalid)
                    begin
                        type_reg   <= s_axis_tuser;
                        need_reg   <= req_need;
                        target_reg <= s_axis_tdata[53:21];
                        addr_reg   <= ADDR_W'(base_reg);
                        i_reg      <= '0;
                        ok_reg     <= 1'b0;
                        grant_reg  <= '0;
                        if (s_axis_tuser == REQ_FREE && s_axis_tdata[53:21] == '0)
                        begin
                            ok_reg    <= 1'b1;
                            state_reg <= S_RESP;
                        end
                        else
                        begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD:
                begin
                    if (i_reg == count_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    cur_reg <= rdata;
                    if (type_reg == REQ_ALLOC && alloc_fit)
                    begin
                        ok_reg    <= 1'b1;
                        grant_reg <= hdr_addr;
                        if (do_split)
                        begin
                            k_reg     <= count_reg;
                            state_reg <= S_SHR;
                        end
                        else
                        begin
                            state_reg <= S_RESP;
                        end
                    end
                    else if (type_reg == REQ_FREE && free_hit)
                    begin
                        ok_reg    <= 1'b1;
                        i_reg     <= '0;
                        state_reg <= S_MSTART;
                    end
                    else
                    begin
                        addr_reg  <= shared_sum;
                        i_reg     <= ip1;
                        state_reg <= S_RD;
                    end
                end
                S_SHR:
                begin
                    // move entry k-1 up to k
                    if (k_reg == ip1)
                    begin
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        state_reg <= S_SHW;
                    end
                end
                S_SHW:
                begin
                    k_reg     <= km1;
                    state_reg <= S_SHR;
                end
                S_SPLIT:
                begin
                    state_reg <= S_SPLIT2;
                end
                S_SPLIT2:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_RESP;
                end
                S_MSTART:
                begin
                    cur_reg   <= e0_reg;
                    state_reg <= S_MRD;
                end
                S_MRD:
                begin
                    if (ip1 >= count_reg)
                    begin
                        state_reg <= S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_MEVAL;
                    end
                end
                S_MEVAL:
                begin
                    if (both_free)
                    begin
                        cur_reg.size <= shared_sum[SIZE_W-1:0];
                        k_reg        <= ip1;
                        state_reg    <= S_SHL;
                    end
                    else
                    begin
                        cur_reg   <= rdata;
                        i_reg     <= ip1;
                        state_reg <= S_MRD;
                    end
                end
                S_SHL:
                begin
                    // move entry k+1 down to k
                    if (kp1 >= count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_MRD;
                    end
                    else
                    begin
                        state_reg <= S_SHLW;
                    end
                end
                S_SHLW:
                begin
                    k_reg     <= kp1;
                    state_reg <= S_SHL;
                end
                S_RESP:
                begin
                    if (m_axis_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[55:54];

    property p_count_range;
        @(posedge clk) disable iff (!rst_n)
            count_reg != '0 && count_reg <= CNT_W'(MAX_BLOCKS);
    endproperty
    assert property (p_count_range) else $error("block count out of range");

    property p_single_accept;
        @(posedge clk) disable iff (!rst_n)
            !(s_axis_tvalid && s_axis_tready && cfg_valid && cfg_ready);
    endproperty
    assert property (p_single_accept) else $error("request and write taken together");

    property p_grant_ok;
        @(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && grant_reg != '0 |-> ok_reg;
    endproperty
    assert property (p_grant_ok) else $error("grant without ok");

    property p_resp_hold;
        @(posedge clk) disable iff (!rst_n)
            m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty
    assert property (p_resp_hold) else $error("response changed under stall");

endmodule

@@ rtl/core/ffba_ram.sv @@
// ----------------------------------------------------------------------------
// ffba_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ verif/first_fit_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_tb
// Self-checking bench: allocate and free requests with random content and
// flow control are scored against a block-table predictor.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    typedef struct {
        logic [0:0]        kind;
        logic [SIZE_W-1:0] nbytes;
        logic [ADDR_W-1:0] addr;
        int                pick;
        bit                drain;
    } req_t;

    typedef struct {
        bit                ok;
        logic [ADDR_W-1:0] grant;
    } resp_t;

    localparam int PICK_NONE = 0;
    localparam int PICK_LIVE = 1;
    localparam int PICK_GONE = 2;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [55:0]       s_axis_tdata = '0;
    logic              s_axis_tuser = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = REG_BASE;
    logic [31:0]       cfg_data = '0;

    req_t              req_q[$];
    resp_t             resp_q[$];
    logic [ADDR_W-1:0] live_addrs[$];
    logic [ADDR_W-1:0] gone_addrs[$];

    logic [BASE_W-1:0] tbl_base;
    logic [SIZE_W-1:0] tbl_bytes;
    logic [SIZE_W-1:0] tbl_size[MAX_BLOCKS];
    bit                tbl_free[MAX_BLOCKS];
    int                tbl_count;

    req_t              cur;
    int                burst_left = 0;
    int                gap_left = 0;
    int                stall_mode = 0;
    int                mode_left = 0;
    int                cfg_writes = 0;
    int                errors = 0;
    int                n_req = 0;
    int                n_grants = 0;
    int                n_fails = 0;
    int                n_frees = 0;

    always #5 clk = ~clk;

    first_fit_block_allocator i_dut (.*);

    function automatic void table_reset();
        for (int i = 0; i < MAX_BLOCKS; i++)
        begin
            tbl_size[i] = '0;
            tbl_free[i] = 0;
        end
        tbl_size[0] = (tbl_bytes >= HDR) ? tbl_bytes - HDR : '0;
        tbl_free[0] = 1;
        tbl_count = 1;
    endfunction

    function automatic void coalesce();
        int i;
        i = 0;
        while (i + 1 < tbl_count)
        begin
            if (tbl_free[i] && tbl_free[i+1])
            begin
                tbl_size[i] = tbl_size[i] + HDR + tbl_size[i+1];
                for (int k = i + 1; k + 1 < tbl_count; k++)
                begin
                    tbl_size[k] = tbl_size[k+1];
                    tbl_free[k] = tbl_free[k+1];
                end
                tbl_count--;
                tbl_size[tbl_count] = '0;
                tbl_free[tbl_count] = 0;
            end
            else
                i++;
        end
    endfunction

    function automatic resp_t allocate(logic [SIZE_W-1:0] nbytes);
        resp_t r;
        longint unsigned need;
        longint unsigned a;
        r.ok = 0;
        r.grant = '0;
        need = (longint'(nbytes) + ALIGN_BYTES - 1) & ~longint'(ALIGN_BYTES - 1);
        a = tbl_base;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_free[i] && tbl_size[i] >= need)
            begin
                if (tbl_size[i] >= need + HEADER_BYTES + ALIGN_BYTES
                    && tbl_count < MAX_BLOCKS)
                begin
                    for (int k = tbl_count; k > i + 1; k--)
                    begin
                        tbl_size[k] = tbl_size[k-1];
                        tbl_free[k] = tbl_free[k-1];
                    end
                    tbl_size[i+1] = tbl_size[i] - need - HEADER_BYTES;
                    tbl_free[i+1] = 1;
                    tbl_size[i] = need;
                    tbl_count++;
                end
                tbl_free[i] = 0;
                r.ok = 1;
                r.grant = ADDR_W'(a + HEADER_BYTES);
                return r;
            end
            a += HEADER_BYTES + tbl_size[i];
        end
        return r;
    endfunction

    function automatic bit release_block(logic [ADDR_W-1:0] target);
        longint unsigned a;
        a = tbl_base;
        if (target == '0)
            return 1;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (a + HEADER_BYTES == target)
            begin
                tbl_free[i] = 1;
                coalesce();
                return 1;
            end
            a += HEADER_BYTES + tbl_size[i];
        end
        return 0;
    endfunction

    function automatic resp_t predict_response(req_t rq);
        resp_t r;
        r.grant = '0;
        if (rq.kind == REQ_ALLOC)
        begin
            r = allocate(rq.nbytes);
            if (r.ok)
            begin
                live_addrs.push_back(r.grant);
                n_grants++;
            end
            else
                n_fails++;
        end
        else
        begin
            r.ok = release_block(rq.addr);
            n_frees++;
            foreach (live_addrs[i])
                if (live_addrs[i] == rq.addr && r.ok)
                begin
                    gone_addrs.push_back(rq.addr);
                    live_addrs.delete(i);
                    break;
                end
        end
        return r;
    endfunction

    function automatic req_t make_req(logic [0:0] kind, int nbytes, longint addr, int pick);
        req_t rq;
        rq.kind = kind;
        rq.nbytes = SIZE_W'(nbytes);
        rq.addr = ADDR_W'(addr);
        rq.pick = pick;
        rq.drain = 0;
        return rq;
    endfunction

    function automatic longint rand_addr();
        return {$urandom_range(0, 1), $urandom()};
    endfunction

    function automatic req_t random_req();
        int r;
        int nb;
        r = $urandom_range(0, 99);
        nb = $urandom_range(0, 255);
        if (r < 8)
            nb = $urandom_range(0, (1 << 21) - 1);
        else if (r < 14)
            nb = $urandom_range(0, tbl_bytes);
        if (r < 55)
            return make_req(REQ_ALLOC, nb, rand_addr(), PICK_NONE);
        if (r < 85)
            return make_req(REQ_FREE, $urandom(), rand_addr(), PICK_LIVE);
        if (r < 90)
            return make_req(REQ_FREE, $urandom(), rand_addr(), PICK_GONE);
        if (r < 94)
            return make_req(REQ_FREE, $urandom(), 0, PICK_NONE);
        return make_req(REQ_FREE, $urandom(), rand_addr(), PICK_NONE);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                resp_q.push_back(predict_response(cur));
                n_req++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (req_q.size() == 0
                         || (req_q[0].drain && (resp_q.size() != 0 || s_axis_tvalid)))
                    s_axis_tvalid <= 1'b0;
                else
                begin
                    cur = req_q.pop_front();
                    if (cur.pick == PICK_LIVE && live_addrs.size() > 0)
                        cur.addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
                    else if (cur.pick == PICK_GONE && gone_addrs.size() > 0)
                        cur.addr = gone_addrs[$urandom_range(0, gone_addrs.size() - 1)];
                    s_axis_tdata  <= {2'b00, cur.addr, cur.nbytes};
                    s_axis_tuser  <= cur.kind;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (resp_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response ok=%0b grant=%h",
                                 m_axis_tdata[0], m_axis_tdata[33:1]);
                end
                else
                begin
                    resp_t e;
                    e = resp_q.pop_front();
                    if (m_axis_tdata[0] !== e.ok || m_axis_tdata[33:1] !== e.grant)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected ok=%0b grant=%h, got ok=%0b grant=%h",
                                     e.ok, e.grant, m_axis_tdata[0], m_axis_tdata[33:1]);
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(50, 400);
            end
            else
                mode_left--;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    always @(posedge clk)
        if (cfg_valid && cfg_ready)
            cfg_writes <= cfg_writes + 1;

    task automatic wait_idle();
        while (req_q.size() != 0 || resp_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        int target;
        target = cfg_writes + 1;
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        wait (cfg_writes == target);
        cfg_valid <= 1'b0;
        if (idx == REG_BASE)
            tbl_base = value;
        else
            tbl_bytes = value[SIZE_W-1:0];
        table_reset();
        live_addrs.delete();
        gone_addrs.delete();
    endtask

    task automatic run_random(int n);
        req_t rq;
        for (int i = 0; i < n; i++)
        begin
            rq = random_req();
            rq.drain = (i == n / 2);
            req_q.push_back(rq);
        end
    endtask

    initial
    begin
        tbl_base = '0;
        tbl_bytes = 21'd65536;
        table_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        req_q.push_back(make_req(REQ_ALLOC, 0, rand_addr(), PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 1, rand_addr(), PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 16, rand_addr(), PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 17, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 21'h1FFFFF, 33'h1FFFFFFFF, PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 1048576, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 21'h1FFFFF, 33'h1FFFFFFFF, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 33'd40, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 33'd32, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 33'd32, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 33'd80, PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 65536 - 32 - 200, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 65536, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 0, PICK_LIVE));
        req_q.push_back(make_req(REQ_FREE, 0, 0, PICK_LIVE));
        req_q.push_back(make_req(REQ_FREE, 0, 0, PICK_GONE));
        req_q.push_back(make_req(REQ_ALLOC, 48, 0, PICK_NONE));
        run_random(150);
        wait_idle();

        write_reg(REG_BASE, 32'hFFFFFFF0);
        write_reg(REG_BYTES, 32'd1048576);
        run_random(150);
        wait_idle();

        write_reg(REG_BASE, 32'h0000_1000);
        write_reg(REG_BYTES, 32'd4096);
        for (int i = 0; i < 90; i++)
            req_q.push_back(make_req(REQ_ALLOC, $urandom_range(0, 16), rand_addr(), PICK_NONE));
        run_random(120);
        wait_idle();

        write_reg(REG_BYTES, 32'd32);
        req_q.push_back(make_req(REQ_ALLOC, 0, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_ALLOC, 0, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 0, PICK_LIVE));
        req_q.push_back(make_req(REQ_ALLOC, 1, 0, PICK_NONE));
        wait_idle();

        write_reg(REG_BYTES, 32'd20);
        req_q.push_back(make_req(REQ_ALLOC, 0, 0, PICK_NONE));
        req_q.push_back(make_req(REQ_FREE, 0, 32, PICK_NONE));
        wait_idle();

        write_reg(REG_BASE, $urandom());
        write_reg(REG_BYTES, 32'h1FFFFF);
        run_random(120);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_BASE, ($urandom_range(0, 3) == 0) ? $urandom()
                                                             : ($urandom() & 32'hFFFFFFF0));
            write_reg(REG_BYTES, ($urandom_range(0, 4) == 0) ? $urandom_range(32, 1048576)
                                                             : $urandom_range(32, 6000));
            run_random(140);
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("%0d requests: %0d grants, %0d failed allocates, %0d frees, %0d reg writes",
                 n_req, n_grants, n_fails, n_frees, cfg_writes);
        if (errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #60ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule
